>>> sv/bei_pkg.sv
package bei_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = FRAC_BITS + 1;
   localparam int LVL_W      = FRAC_BITS;

   localparam logic [1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic CSR_TOTAL_LENGTH     = 1'b0;
   localparam logic CSR_LAST_POINT_INDEX = 1'b1;

   localparam logic [31:0]    TOTAL_LENGTH_RESET     = 32'd65536;
   localparam logic [IDX_W-1:0] LAST_POINT_INDEX_RESET = IDX_W'(1);

   typedef struct packed {
      logic [1:0]       cmd;
      logic [31:0]      sample_position;
      logic [IDX_W-1:0] point_index;
      logic [POS_W-1:0] point_position;
      logic [LVL_W-1:0] point_level;
   } req_item_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [IDX_W-1:0] segment_number;
   } rsp_item_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [LVL_W-1:0] lvl;
   } entry_type;

endpackage

>>> sv/bei_ram.sv
module bei_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/breakpoint_envelope_interpolator.sv
// Piecewise-linear envelope generator. A beat with cmd write stores one breakpoint and a beat
// with cmd restart rewinds the segment walk; both take effect at the accepting edge, cause no
// result and leave the block ready in the next cycle. A sample beat occupies the block from the
// accepting edge to the cycle in which rsp_strobe is high: for every breakpoint the walk visits
// a table read, a position scaling and a compare; the slope division when the walk moved on or
// reached the right breakpoint; the restoring division that turns the sample position into a
// fraction; the offset from the left breakpoint; and the bit-serial multiply. The divisions, the
// offset and the multiply share one 50-bit adder. busy is high throughout. The result is presented
// for exactly one cycle and cannot be held off, so the receiver must take it when rsp_strobe is
// high; busy falls in that same cycle and a new beat may be started.
module breakpoint_envelope_interpolator
   import bei_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FETCH, ST_PROD, ST_CMP, ST_SLOPE, ST_SDIV, ST_FINIT, ST_FDIV,
      ST_DIFF, ST_DNEG, ST_MACC, ST_FINAL
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      total_ff, total_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0] seg_ff, seg_in;
   logic [POS_W-1:0] lp_ff, lp_in;
   logic [LVL_W-1:0] ll_ff, ll_in;
   logic             slope_neg_ff, slope_neg_in;
   logic [31:0]      slope_mag_ff, slope_mag_in;
   logic             walked_ff, walked_in;
   entry_type        ent_ff, ent_in;
   logic [48:0]      prod_ff, prod_in;
   logic [31:0]      pos_ff, pos_in;
   logic [31:0]      rem_ff, rem_in;
   logic [47:0]      q_ff, q_in;
   logic [31:0]      den_ff, den_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             div_neg_ff, div_neg_in;
   logic             d_neg_ff, d_neg_in;
   logic [40:0]      ud_ff, ud_in;
   logic [41:0]      acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic        accept;
   logic        ram_we;
   entry_type   ram_wdata;
   entry_type   ram_rdata;
   logic [31:0] len_eff;

   logic [48:0] alu_a;
   logic [48:0] alu_b;
   logic        alu_add;
   logic [49:0] alu_res;
   logic [49:0] alu_b_op;

   logic        reached;
   logic        lvl_ge;
   logic        pos_ge;
   logic [15:0] dl_mag;
   logic [16:0] dp_mag;
   logic        div_ok;
   logic [47:0] q_step;
   logic        acc_big;
   logic [24:0] delta;
   logic [25:0] sum_up;
   logic [LVL_W-1:0] level_out;
   logic        out_neg;

   assign accept    = start && !busy;
   assign ram_we    = accept && (req_item.cmd == CMD_WRITE);
   assign ram_wdata = '{pos: req_item.point_position, lvl: req_item.point_level};
   assign len_eff   = (total_ff == 32'd0) ? 32'd1 : total_ff;

   bei_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_item.point_index),
      .wr_data (ram_wdata),
      .rd_addr (seg_ff),
      .rd_data (ram_rdata)
   );

   // Shared adder: add, or subtract with the borrow in the top bit.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_add = 1'b0;
      case (state_ff)
         ST_SDIV, ST_FDIV: begin
            alu_a = {16'b0, rem_ff, q_ff[47]};
            alu_b = {17'b0, den_ff};
         end
         ST_DIFF: begin
            alu_a = {1'b0, q_ff};
            alu_b = {32'b0, lp_ff};
         end
         ST_DNEG: begin
            alu_a = {32'b0, lp_ff};
            alu_b = {1'b0, q_ff};
         end
         ST_MACC: begin
            alu_a   = {6'b0, acc_ff, 1'b0};
            alu_b   = q_ff[47] ? {8'b0, ud_ff} : 49'b0;
            alu_add = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
      alu_b_op = alu_add ? {1'b0, alu_b} : ~{1'b0, alu_b};
      alu_res  = {1'b0, alu_a} + alu_b_op + {49'b0, !alu_add};
   end

   assign div_ok  = !alu_res[49];
   assign q_step  = {q_ff[46:0], div_ok};
   assign acc_big = (alu_res[48:41] != 8'b0) || (alu_res[40] && (alu_res[39:0] != 40'b0));

   assign reached = {1'b0, pos_ff} >= prod_ff[48:16];
   assign lvl_ge  = ent_ff.lvl >= ll_ff;
   assign pos_ge  = ent_ff.pos >= lp_ff;
   assign dl_mag  = lvl_ge ? (ent_ff.lvl - ll_ff) : (ll_ff - ent_ff.lvl);
   assign dp_mag  = pos_ge ? (ent_ff.pos - lp_ff) : (lp_ff - ent_ff.pos);

   assign out_neg = slope_neg_ff ^ d_neg_ff;
   assign delta   = acc_ff[40:16];
   assign sum_up  = {10'b0, ll_ff} + {1'b0, delta};

   always_comb begin
      if (ovf_ff) begin
         level_out = out_neg ? '0 : '1;
      end else if (out_neg) begin
         level_out = ({9'b0, ll_ff} < delta) ? '0 : (ll_ff - delta[15:0]);
      end else begin
         level_out = (sum_up[25:16] != 10'b0) ? '1 : sum_up[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      seg_in        = seg_ff;
      lp_in         = lp_ff;
      ll_in         = ll_ff;
      slope_neg_in  = slope_neg_ff;
      slope_mag_in  = slope_mag_ff;
      walked_in     = walked_ff;
      ent_in        = ent_ff;
      prod_in       = prod_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      div_neg_in    = div_neg_ff;
      d_neg_in      = d_neg_ff;
      ud_in         = ud_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_TOTAL_LENGTH:     total_in = csr_wdata;
            CSR_LAST_POINT_INDEX: last_in  = csr_wdata[IDX_W-1:0];
            default:              total_in = total_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.cmd)
                  CMD_SAMPLE: begin
                     pos_in    = req_item.sample_position;
                     walked_in = 1'b0;
                     state_in  = ST_FETCH;
                  end
                  CMD_RESTART: begin
                     seg_in       = '0;
                     lp_in        = '0;
                     ll_in        = '0;
                     slope_neg_in = 1'b0;
                     slope_mag_in = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_PROD;
         end
         ST_PROD: begin
            ent_in   = ram_rdata;
            prod_in  = 49'(len_eff) * 49'(ram_rdata.pos);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (reached && (seg_ff < last_ff)) begin
               lp_in     = ent_ff.pos;
               ll_in     = ent_ff.lvl;
               seg_in    = seg_ff + IDX_W'(1);
               walked_in = 1'b1;
               state_in  = ST_FETCH;
            end else if (reached || walked_ff) begin
               state_in = ST_SLOPE;
            end else begin
               state_in = ST_FINIT;
            end
         end
         ST_SLOPE: begin
            if (ent_ff.pos == lp_ff) begin
               ll_in        = ent_ff.lvl;
               slope_neg_in = 1'b0;
               slope_mag_in = '0;
               state_in     = ST_FINIT;
            end else begin
               div_neg_in = (!lvl_ge) ^ (!pos_ge);
               q_in       = {dl_mag, 32'b0};
               rem_in     = '0;
               den_in     = {15'b0, dp_mag};
               cnt_in     = 6'd31;
               state_in   = ST_SDIV;
            end
         end
         ST_SDIV: begin
            rem_in = div_ok ? alu_res[31:0] : alu_a[31:0];
            q_in   = q_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               slope_mag_in = q_step[31:0];
               slope_neg_in = div_neg_ff;
               state_in     = ST_FINIT;
            end
         end
         ST_FINIT: begin
            q_in     = {pos_ff, 16'b0};
            rem_in   = '0;
            den_in   = len_eff;
            cnt_in   = 6'd47;
            state_in = ST_FDIV;
         end
         ST_FDIV: begin
            rem_in = div_ok ? alu_res[31:0] : alu_a[31:0];
            q_in   = q_step;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF, ST_DNEG: begin
            if ((state_ff == ST_DIFF) && !div_ok) begin
               state_in = ST_DNEG;
            end else begin
               d_neg_in = (state_ff == ST_DNEG);
               ud_in    = alu_res[40:0];
               ovf_in   = (slope_mag_ff != 32'b0) && (alu_res[48:41] != 8'b0);
               acc_in   = '0;
               q_in     = {slope_mag_ff, 16'b0};
               cnt_in   = 6'd31;
               state_in = ST_MACC;
            end
         end
         ST_MACC: begin
            if (!ovf_ff) begin
               acc_in = alu_res[41:0];
               ovf_in = acc_big;
            end
            q_in   = {q_ff[46:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp_in        = '{level: level_out, segment_number: seg_ff};
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= TOTAL_LENGTH_RESET;
         last_ff       <= LAST_POINT_INDEX_RESET;
         seg_ff        <= '0;
         lp_ff         <= '0;
         ll_ff         <= '0;
         slope_neg_ff  <= 1'b0;
         slope_mag_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         last_ff       <= last_in;
         seg_ff        <= seg_in;
         lp_ff         <= lp_in;
         ll_ff         <= ll_in;
         slope_neg_ff  <= slope_neg_in;
         slope_mag_ff  <= slope_mag_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      walked_ff  <= walked_in;
      ent_ff     <= ent_in;
      prod_ff    <= prod_in;
      pos_ff     <= pos_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      den_ff     <= den_in;
      cnt_ff     <= cnt_in;
      div_neg_ff <= div_neg_in;
      d_neg_ff   <= d_neg_in;
      ud_ff      <= ud_in;
      acc_ff     <= acc_in;
      ovf_ff     <= ovf_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_strobe_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_FINAL))
      else $error("result strobe without a finished sample");

   a_no_result_beat_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.cmd != CMD_SAMPLE)) |=> (!busy && !rsp_strobe))
      else $error("write or restart beat left the block busy");

   a_sample_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.cmd == CMD_SAMPLE)) |=> busy)
      else $error("sample beat not taken up");

   a_slope_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SDIV || state_ff == ST_MACC) |-> (cnt_ff <= 6'd31))
      else $error("iteration count out of range");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MACC && !ovf_ff) |-> (acc_ff <= 42'h100_0000_0000))
      else $error("product accumulator passed the saturation bound");

endmodule
